// ===== hw/rtl/stpg_pkg.sv =====
`default_nettype none

package stpg_pkg;

    // Width of one trapezoid segment duration.
    localparam int SEG_W = 16;

    // Quarter-wave sine polynomial coefficients, Q15.
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21023;
    localparam logic [15:0] SIN_C = 16'd2320;
    localparam logic [15:0] SIN_ONE = 16'd32768;

    typedef enum logic [1:0] {
        MODE_CONST      = 2'd0,
        MODE_SINE       = 2'd1,
        MODE_SINE_CLAMP = 2'd2,
        MODE_TRAP       = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_BASE      = 3'd1,
        REG_PEAK      = 3'd2,
        REG_END       = 3'd3,
        REG_CLAMP_LO  = 3'd4,
        REG_CLAMP_HI  = 3'd5,
        REG_PHASE     = 3'd6,
        REG_SEGMENTS  = 3'd7
    } t_reg;

endpackage

`default_nettype wire

// ===== hw/rtl/sine_trapezoid_setpoint_generator_unit.sv =====
`default_nettype none

// Setpoint generator: constant, sine, clamped sine or trapezoid profile.
// Input channel: i_valid / o_stall with i_time_ticks (signed ticks, negative
// values count as tick zero). Output channel: o_valid / i_stall with
// o_target_level (signed Q.8, saturated to LEVEL_WIDTH bits).
// A request is taken on a clock edge with valid high and stall low.
// Configuration goes through the APB-style port; 64-bit data, register i at
// byte address 8*i, pready tied high. Write only while the block is idle.
// From accept to o_valid a request passes through 8 front stages (segment
// select, phase multiply, four sine polynomial stages, amplitude multiply,
// round/clamp), then a row of LEVEL_WIDTH + 1 division cells, one quotient
// bit each, for the ramp interpolation, then the output register.
// Throughput: one request per cycle while i_stall is low; every stage has its
// own valid bit, so bubbles close up and new requests enter while a result waits.
// When the receiver stalls the output register holds and stages fill up
// behind it; o_stall rises only once the first stage is held as well.
// Reset (synchronous, active low) empties the pipeline and clears all
// configuration registers to zero (constant mode, level zero).
module sine_trapezoid_setpoint_generator_unit #(
    parameter int LEVEL_WIDTH = 24,
    parameter int PHASE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [31:0]            i_time_ticks,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [LEVEL_WIDTH-1:0]      o_target_level,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [5:0]                    paddr,
    input  wire logic [63:0]                   pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);

    localparam int LW = LEVEL_WIDTH;
    localparam int PW = PHASE_WIDTH;
    localparam int SG = stpg_pkg::SEG_W;
    localparam int QB = LW + 1;            // quotient bits = division cells
    localparam int NW = QB + SG;           // ramp numerator width
    localparam int SW = 2 * LW + 1;        // side payload through the cells
    localparam int NF = 8;                 // front stages

    localparam logic signed [LW+3:0] LMAX = {5'b0, {(LW-1){1'b1}}};
    localparam logic signed [LW+3:0] LMIN = ~LMAX;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    stpg_pkg::t_mode        r_mode;
    logic signed [LW-1:0]   r_base;
    logic signed [LW-1:0]   r_peak;
    logic signed [LW-1:0]   r_end;
    logic signed [LW-1:0]   r_clo;
    logic signed [LW-1:0]   r_chi;
    logic [PW-1:0]          r_step;
    logic [PW-1:0]          r_pstart;
    logic [63:0]            r_seg;

    logic                   w_wr;
    stpg_pkg::t_reg         w_idx;

    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = stpg_pkg::t_reg'(paddr[5:3]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= stpg_pkg::MODE_CONST;
            r_base   <= '0;
            r_peak   <= '0;
            r_end    <= '0;
            r_clo    <= '0;
            r_chi    <= '0;
            r_step   <= '0;
            r_pstart <= '0;
            r_seg    <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                stpg_pkg::REG_MODE:     r_mode   <= stpg_pkg::t_mode'(pwdata[1:0]);
                stpg_pkg::REG_BASE:     r_base   <= pwdata[LW-1:0];
                stpg_pkg::REG_PEAK:     r_peak   <= pwdata[LW-1:0];
                stpg_pkg::REG_END:      r_end    <= pwdata[LW-1:0];
                stpg_pkg::REG_CLAMP_LO: r_clo    <= pwdata[LW-1:0];
                stpg_pkg::REG_CLAMP_HI: r_chi    <= pwdata[LW-1:0];
                stpg_pkg::REG_PHASE: begin
                    r_step   <= pwdata[PW-1:0];
                    r_pstart <= pwdata[32+PW-1:32];
                end
                stpg_pkg::REG_SEGMENTS: r_seg    <= pwdata;
                default: ;
            endcase
        end
    end

    // read back the stored bits, zero-extended
    always_comb begin
        unique case (w_idx)
            stpg_pkg::REG_MODE:     prdata = 64'(r_mode);
            stpg_pkg::REG_BASE:     prdata = 64'($unsigned(r_base));
            stpg_pkg::REG_PEAK:     prdata = 64'($unsigned(r_peak));
            stpg_pkg::REG_END:      prdata = 64'($unsigned(r_end));
            stpg_pkg::REG_CLAMP_LO: prdata = 64'($unsigned(r_clo));
            stpg_pkg::REG_CLAMP_HI: prdata = 64'($unsigned(r_chi));
            stpg_pkg::REG_PHASE:    prdata = {32'(r_pstart), 32'(r_step)};
            stpg_pkg::REG_SEGMENTS: prdata = r_seg;
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Stage handshake: each front stage moves when empty or when the
    // stage after it moves.
    // ---------------------------------------------------------------
    logic [NF-1:0] r_vld;
    logic [NF:0]   w_rdy;
    logic [NF-1:0] w_vin;
    logic          w_out_rdy;

    assign w_vin = {r_vld[NF-2:0], i_valid};

    for (genvar k = 0; k < NF; k++) begin : g_hs
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= w_vin[k];
            end
        end
    end

    assign o_stall = !w_rdy[0];

    // ---------------------------------------------------------------
    // F1: clip time, pick trapezoid segment
    // ---------------------------------------------------------------
    logic [30:0]          w_t;
    logic [SG+1:0]        w_b1, w_b2, w_b3, w_b4;
    logic signed [LW-1:0] n_start;
    logic signed [LW:0]   n_delta;
    logic [SG-1:0]        n_u;
    logic [SG-1:0]        n_len;
    logic [30:0]          w_u_rise, w_u_fall;

    assign w_t      = i_time_ticks[31] ? 31'd0 : i_time_ticks[30:0];
    assign w_b1     = (SG+2)'(r_seg[15:0]);
    assign w_b2     = w_b1 + (SG+2)'(r_seg[31:16]);
    assign w_b3     = w_b2 + (SG+2)'(r_seg[47:32]);
    assign w_b4     = w_b3 + (SG+2)'(r_seg[63:48]);
    assign w_u_rise = w_t - 31'(w_b1);
    assign w_u_fall = w_t - 31'(w_b3);

    // hold segments use a zero delta over a unit length: quotient zero
    always_comb begin
        n_start = r_end;
        n_delta = '0;
        n_u     = '0;
        n_len   = SG'(1);
        priority if (w_t < 31'(w_b1)) begin
            n_start = r_base;
        end else if (w_t < 31'(w_b2)) begin
            n_start = r_base;
            n_delta = (LW+1)'(r_peak) - (LW+1)'(r_base);
            n_u     = w_u_rise[SG-1:0];
            n_len   = r_seg[31:16];
        end else if (w_t < 31'(w_b3)) begin
            n_start = r_peak;
        end else if (w_t < 31'(w_b4)) begin
            n_start = r_peak;
            n_delta = (LW+1)'(r_end) - (LW+1)'(r_peak);
            n_u     = w_u_fall[SG-1:0];
            n_len   = r_seg[63:48];
        end else begin
            n_start = r_end;
        end
    end

    logic [30:0]          r_f1_t;
    logic signed [LW-1:0] r_f1_start;
    logic signed [LW:0]   r_f1_delta;
    logic [SG-1:0]        r_f1_u;
    logic [SG-1:0]        r_f1_len;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && w_vin[0]) begin
            r_f1_t     <= w_t;
            r_f1_start <= n_start;
            r_f1_delta <= n_delta;
            r_f1_u     <= n_u;
            r_f1_len   <= n_len;
        end
    end

    // ---------------------------------------------------------------
    // F2: phase multiply and offset, ramp numerator |delta|*u + len/2
    // ---------------------------------------------------------------
    logic [PW+30:0] w_pm;
    logic [LW:0]    w_absd;
    logic [NW-1:0]  w_nm;

    assign w_pm   = r_step * r_f1_t;
    assign w_absd = r_f1_delta[LW] ? (LW+1)'(-r_f1_delta) : r_f1_delta;
    assign w_nm   = w_absd * r_f1_u;

    logic [PW-1:0]        r_f2_phase;
    logic [NW-1:0]        r_f2_n;
    logic [SG-1:0]        r_f2_den;
    logic                 r_f2_neg;
    logic signed [LW-1:0] r_f2_start;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1] && w_vin[1]) begin
            r_f2_phase <= w_pm[PW-1:0] + r_pstart;
            r_f2_n     <= w_nm + NW'(r_f1_len >> 1);
            r_f2_den   <= r_f1_len;
            r_f2_neg   <= r_f1_delta[LW];
            r_f2_start <= r_f1_start;
        end
    end

    // trapezoid operands ride along the sine stages as one bundle
    localparam int TB = NW + SG + 1 + LW;
    logic [TB-1:0] w_f2_trap;
    logic [TB-1:0] r_s1_trap, r_s2_trap, r_s3_trap, r_s4_trap, r_s5_trap, r_s6_trap;

    assign w_f2_trap = {r_f2_n, r_f2_den, r_f2_neg, r_f2_start};

    // ---------------------------------------------------------------
    // S1: quadrant fold, z^2
    // ---------------------------------------------------------------
    logic [31:0] w_p32;
    logic [15:0] w_z;
    logic [31:0] w_zz;

    assign w_p32 = 32'(r_f2_phase) << (32 - PW);
    assign w_z   = w_p32[30] ? (stpg_pkg::SIN_ONE - {1'b0, w_p32[29:15]})
                             : {1'b0, w_p32[29:15]};
    assign w_zz  = w_z * w_z;

    logic [15:0] r_s1_z, r_s1_z2;
    logic [1:0]  r_s1_quad;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2] && w_vin[2]) begin
            r_s1_z    <= w_z;
            r_s1_z2   <= w_zz[30:15];
            r_s1_quad <= w_p32[31:30];
            r_s1_trap <= w_f2_trap;
        end
    end

    // S2: B - z2*C
    logic [31:0] w_m2;
    assign w_m2 = r_s1_z2 * stpg_pkg::SIN_C;

    logic [15:0] r_s2_z, r_s2_z2, r_s2_inner;
    logic [1:0]  r_s2_quad;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3] && w_vin[3]) begin
            r_s2_z     <= r_s1_z;
            r_s2_z2    <= r_s1_z2;
            r_s2_inner <= stpg_pkg::SIN_B - w_m2[30:15];
            r_s2_quad  <= r_s1_quad;
            r_s2_trap  <= r_s1_trap;
        end
    end

    // S3: A - z2*inner
    logic [31:0] w_m3;
    assign w_m3 = r_s2_z2 * r_s2_inner;

    logic [15:0] r_s3_z, r_s3_inner;
    logic [1:0]  r_s3_quad;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4] && w_vin[4]) begin
            r_s3_z     <= r_s2_z;
            r_s3_inner <= stpg_pkg::SIN_A - w_m3[30:15];
            r_s3_quad  <= r_s2_quad;
            r_s3_trap  <= r_s2_trap;
        end
    end

    // S4: z*inner, cap at one, apply sign of lower half-turn
    logic [31:0]        w_m4;
    logic [15:0]        w_scap;
    logic signed [16:0] w_sp;

    assign w_m4   = r_s3_z * r_s3_inner;
    assign w_scap = (w_m4[31:15] > 17'(stpg_pkg::SIN_ONE)) ? stpg_pkg::SIN_ONE
                                                           : w_m4[30:15];
    assign w_sp   = $signed({1'b0, w_scap});

    logic signed [16:0] r_s4_sv;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5] && w_vin[5]) begin
            r_s4_sv   <= r_s3_quad[1] ? -w_sp : w_sp;
            r_s4_trap <= r_s3_trap;
        end
    end

    // S5: amplitude multiply
    logic signed [LW+16:0] r_s5_prod;

    always_ff @(posedge i_clk) begin
        if (w_rdy[6] && w_vin[6]) begin
            r_s5_prod <= (LW+17)'(r_peak) * (LW+17)'(r_s4_sv);
            r_s5_trap <= r_s4_trap;
        end
    end

    // S6: round half up, add offset (constant mode: base only), clamp in clamped-sine mode, saturate
    logic signed [LW+17:0] w_rnd;
    logic signed [LW+2:0]  w_sh;
    logic signed [LW+3:0]  w_r;
    logic signed [LW+3:0]  n_res;
    logic                  w_clamp_on;

    assign w_rnd      = (LW+18)'(r_s5_prod) + (LW+18)'(16384);
    assign w_sh       = w_rnd[LW+17:15];
    assign w_r        = (LW+4)'(r_base) + (LW+4)'(w_sh);
    assign w_clamp_on = (r_mode == stpg_pkg::MODE_SINE_CLAMP) && (r_clo <= r_chi);

    always_comb begin
        n_res = w_r;
        if (r_mode == stpg_pkg::MODE_CONST) begin
            n_res = (LW+4)'(r_base);
        end else if (w_clamp_on) begin
            priority if (w_r > (LW+4)'(r_chi)) begin
                n_res = (LW+4)'(r_chi);
            end else if (w_r < (LW+4)'(r_clo)) begin
                n_res = (LW+4)'(r_clo);
            end else begin
                n_res = w_r;
            end
        end
        priority if (n_res > LMAX) begin
            n_res = LMAX;
        end else if (n_res < LMIN) begin
            n_res = LMIN;
        end else begin
            n_res = n_res;
        end
    end

    logic signed [LW-1:0] r_s6_res;

    always_ff @(posedge i_clk) begin
        if (w_rdy[7] && w_vin[7]) begin
            r_s6_res  <= n_res[LW-1:0];
            r_s6_trap <= r_s5_trap;
        end
    end

    // ---------------------------------------------------------------
    // Division row: ramp numerator / segment length, one bit per cell
    // ---------------------------------------------------------------
    logic [NW-1:0]        w_dn;
    logic [SG-1:0]        w_dd;
    logic                 w_dneg;
    logic signed [LW-1:0] w_dstart;

    assign {w_dn, w_dd, w_dneg, w_dstart} = r_s6_trap;

    logic [QB:0]         w_cv;
    logic [QB:0]         w_cr;
    logic [SG-1:0]       w_crem  [QB+1];
    logic [QB-1:0]       w_cword [QB+1];
    logic [SG-1:0]       w_cden  [QB+1];
    logic [SW-1:0]       w_cside [QB+1];

    assign w_cv[0]    = r_vld[NF-1];
    assign w_rdy[NF]  = w_cr[0];
    assign w_crem[0]  = w_dn[NW-1:QB];
    assign w_cword[0] = w_dn[QB-1:0];
    assign w_cden[0]  = w_dd;
    assign w_cside[0] = {r_s6_res, w_dstart, w_dneg};
    assign w_cr[QB]   = w_out_rdy;

    for (genvar j = 0; j < QB; j++) begin : g_div
        stpg_div_cell #(
            .QB (QB),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[j]),
            .o_ready (w_cr[j]),
            .i_ready (w_cr[j+1]),
            .o_valid (w_cv[j+1]),
            .i_rem   (w_crem[j]),
            .i_word  (w_cword[j]),
            .i_den   (w_cden[j]),
            .i_side  (w_cside[j]),
            .o_rem   (w_crem[j+1]),
            .o_word  (w_cword[j+1]),
            .o_den   (w_cden[j+1]),
            .o_side  (w_cside[j+1])
        );
    end

    // ---------------------------------------------------------------
    // Output register: pick trapezoid or sine/constant result
    // ---------------------------------------------------------------
    logic signed [LW-1:0] w_ores;
    logic signed [LW-1:0] w_ostart;
    logic                 w_oneg;
    logic signed [LW+1:0] w_qs;
    logic signed [LW+1:0] w_trap;

    assign {w_ores, w_ostart, w_oneg} = w_cside[QB];
    assign w_qs   = $signed({1'b0, w_cword[QB]});
    assign w_trap = (LW+2)'(w_ostart) + (w_oneg ? -w_qs : w_qs);

    logic                 r_ov;
    logic signed [LW-1:0] r_out;

    assign w_out_rdy = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_rdy) begin
            r_ov <= w_cv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_cv[QB]) begin
            r_out <= (r_mode == stpg_pkg::MODE_TRAP) ? w_trap[LW-1:0] : w_ores;
        end
    end

    assign o_valid        = r_ov;
    assign o_target_level = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_needs_full_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_vld[0])
        else $error("stall raised with empty first stage");

    a_sine_within_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r_s4_sv <= 17'sd32768) && (r_s4_sv >= -17'sd32768))
        else $error("sine magnitude above one");

    a_clamp_respected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[7] && (r_mode == stpg_pkg::MODE_SINE_CLAMP) && (r_clo <= r_chi))
            |-> (r_s6_res >= r_clo) && (r_s6_res <= r_chi))
        else $error("clamped sine outside bounds");

endmodule

`default_nettype wire

// ===== hw/rtl/stpg_div_cell.sv =====
`default_nettype none

// One restoring-division cell: retires one quotient bit per request and
// passes the partial remainder, the shifting numerator/quotient word, the
// divisor and the side payload on to the next cell.
module stpg_div_cell #(
    parameter int QB = 25,
    parameter int SW = 49
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_ready,
    output logic                              o_valid,
    input  wire logic [stpg_pkg::SEG_W-1:0]   i_rem,
    input  wire logic [QB-1:0]                i_word,
    input  wire logic [stpg_pkg::SEG_W-1:0]   i_den,
    input  wire logic [SW-1:0]                i_side,
    output logic [stpg_pkg::SEG_W-1:0]        o_rem,
    output logic [QB-1:0]                     o_word,
    output logic [stpg_pkg::SEG_W-1:0]        o_den,
    output logic [SW-1:0]                     o_side
);

    localparam int RW = stpg_pkg::SEG_W;

    logic          r_v;
    logic [RW-1:0] r_rem;
    logic [QB-1:0] r_word;
    logic [RW-1:0] r_den;
    logic [SW-1:0] r_side;

    logic [RW:0]   w_trial;
    logic [RW:0]   w_diff;
    logic          w_ge;
    logic [RW-1:0] n_rem;
    logic [QB-1:0] n_word;

    assign w_trial = {i_rem, i_word[QB-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign n_rem   = w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
    assign n_word  = {i_word[QB-2:0], w_ge};

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_word <= n_word;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_word  = r_word;
    assign o_den   = r_den;
    assign o_side  = r_side;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> (r_den != '0))
        else $error("division by zero in cell");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && !i_ready) |=> r_v)
        else $error("cell dropped a held request");

endmodule

`default_nettype wire
